// ===== design/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types for the set-associative LRU lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none
package sacl_pkg;
	typedef struct packed {
		logic rd;   // accept: register address for the row read
		logic upd;  // write back row, bump counters
	} cmd_t;
	typedef struct packed {
		logic hit;
		logic evicted;
	} stat_t;
endpackage
`default_nettype wire

// ===== design/sacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: accept, read row, resolve/write back, present result.
// ----------------------------------------------------------------------------
`default_nettype none
module sacl_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         valid,
	output logic              ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	output sacl_pkg::cmd_t    cmd
);
	typedef enum logic [1:0] {IDLE, LOOK, UPD, OUT} st_t;
	st_t state_q;

	assign ready = (state_q == IDLE);
	assign out_valid = (state_q == OUT);
	assign cmd.rd = (state_q == IDLE) && valid;
	// row data lands at the end of LOOK, so resolve in UPD
	assign cmd.upd = (state_q == UPD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: if (valid) state_q <= LOOK;
				LOOK: state_q <= UPD;
				UPD:  state_q <= OUT;
				OUT:  if (out_ready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> out_valid && !ready) else $error("result not presented");
	a_no_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && !ready) else $error("accept while busy");
	a_rd_upd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> ##1 cmd.upd) else $error("missing update");
endmodule
`default_nettype wire

// ===== design/sacl_dp.sv =====
// ----------------------------------------------------------------------------
// sacl_dp
// Tag/rank memory row, parallel compare, LRU update and counters.
// ----------------------------------------------------------------------------
`default_nettype none
module sacl_dp #(
	parameter int NUM_SETS = 64,
	parameter int WAYS = 4,
	parameter int LINE_BYTES = 32,
	parameter int ADDR_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [ADDR_WIDTH-1:0] address,
	input  sacl_pkg::cmd_t             cmd,
	output sacl_pkg::stat_t            stat,
	output logic [1:0]                 way,
	output logic [31:0]                hit_total,
	output logic [31:0]                miss_total
);
	localparam int OB = $clog2(LINE_BYTES + 1) - 1;
	localparam int IB = $clog2(NUM_SETS + 1) - 1;
	localparam int TW = (ADDR_WIDTH - OB - IB) > 0 ? ADDR_WIDTH - OB - IB : 1;
	localparam int SW = (IB > 0) ? IB : 1;
	localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RB = WB;

	logic [TW-1:0] tag_mem [NUM_SETS][WAYS];
	logic [RB-1:0] rank_mem [NUM_SETS][WAYS];
	logic [NUM_SETS*WAYS-1:0] vld_q;

	logic [ADDR_WIDTH-1:0] a_q;
	logic [SW-1:0] set_q;
	logic [TW-1:0] tag_q;
	logic [TW-1:0] rt_q [WAYS];
	logic [RB-1:0] rr_q [WAYS];
	logic [WAYS-1:0] rv_q;

	always_comb begin
		set_q = SW'((a_q >> OB) % NUM_SETS);
		tag_q = (OB + IB >= ADDR_WIDTH) ? '0 : TW'(a_q >> (OB + IB));
	end

	logic hit_c, free_c;
	logic [WB-1:0] hw_c, fw_c, ew_c, w_c;
	logic [RB-1:0] lim_c;
	logic [RB-1:0] nr_c [WAYS];
	always_comb begin
		hit_c = 1'b0; free_c = 1'b0; hw_c = '0; fw_c = '0; ew_c = '0;
		for (int k = 0; k < WAYS; k++) begin
			if (!hit_c && rv_q[k] && rt_q[k] == tag_q) begin
				hit_c = 1'b1; hw_c = WB'(k);
			end
			if (!free_c && !rv_q[k]) begin
				free_c = 1'b1; fw_c = WB'(k);
			end
			if (rr_q[k] > rr_q[ew_c]) ew_c = WB'(k);
		end
		w_c = hit_c ? hw_c : (free_c ? fw_c : ew_c);
		lim_c = rr_q[w_c];
		for (int k = 0; k < WAYS; k++) begin
			nr_c[k] = rr_q[k];
			if (WB'(k) == w_c) nr_c[k] = '0;
			else if (rv_q[k] && (!hit_c || rr_q[k] < lim_c)
				&& rr_q[k] != RB'(WAYS - 1)) nr_c[k] = rr_q[k] + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) a_q <= address;
		for (int k = 0; k < WAYS; k++) begin
			rt_q[k] <= tag_mem[set_q][k];
			rr_q[k] <= rank_mem[set_q][k];
			if (cmd.upd) begin
				rank_mem[set_q][k] <= nr_c[k];
				if (!hit_c && WB'(k) == w_c) tag_mem[set_q][k] <= tag_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0; hit_total <= '0; miss_total <= '0;
			stat <= '0; way <= '0; rv_q <= '0;
		end else begin
			for (int k = 0; k < WAYS; k++) rv_q[k] <= vld_q[set_q*WAYS + k];
			if (cmd.upd) begin
				stat.hit <= hit_c;
				stat.evicted <= !hit_c && !free_c;
				way <= 2'(w_c);
				if (!hit_c) vld_q[set_q*WAYS + w_c] <= 1'b1;
				if (hit_c && hit_total != '1) hit_total <= hit_total + 1'b1;
				if (!hit_c && miss_total != '1) miss_total <= miss_total + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/set_assoc_cache_lru_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_unit
// Set-associative tag lookup with per-set LRU replacement and hit/miss totals.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// request  | valid / ready      | address
// result   | out_valid/out_ready| hit, way, evicted, hit_total, miss_total
//
// A request is accepted (address registered), its row read, then compared
// with ranks, tag and counters written back; the result is held until taken.
// Set row memory has one read port; one request is in flight at a time.
// Reset clears valid bits, counters and control; tags need no reset.
// A stalled result blocks the next request.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_cache_lru_lookup_unit #(
	parameter int NUM_SETS = 64,
	parameter int WAYS = 4,
	parameter int LINE_BYTES = 32,
	parameter int ADDR_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  valid,
	output logic                       ready,
	input  wire logic [ADDR_WIDTH-1:0] address,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       hit,
	output logic [1:0]                 way,
	output logic                       evicted,
	output logic [31:0]                hit_total,
	output logic [31:0]                miss_total
);
	sacl_pkg::cmd_t  cmd;
	sacl_pkg::stat_t stat;

	sacl_ctrl u_ctrl (.clk, .arst_n, .valid, .ready, .out_valid, .out_ready, .cmd);

	sacl_dp #(.NUM_SETS(NUM_SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES),
		.ADDR_WIDTH(ADDR_WIDTH)) u_dp (
		.clk, .arst_n, .address, .cmd, .stat, .way, .hit_total, .miss_total);

	assign hit = stat.hit;
	assign evicted = stat.evicted;
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the set-associative LRU lookup unit. Lookup requests
// (directed corner cases, then random traffic biased to a few sets and tags)
// are driven through valid/ready. A cache model in the bench predicts hit,
// way, eviction and totals, and each result is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SETS   = 64;
	localparam int WAYS       = 4;
	localparam int OFF_BITS   = 5;
	localparam int IDX_BITS   = 6;
	localparam int TAG_BITS   = 32 - OFF_BITS - IDX_BITS;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE     = 10;

	typedef struct packed {
		logic        hit;
		logic [1:0]  way;
		logic        evicted;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} lookup_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic ready;
	logic [31:0] address = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic [1:0] way;
	logic evicted;
	logic [31:0] hit_total;
	logic [31:0] miss_total;

	set_assoc_cache_lru_lookup_unit i_dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.address(address), .out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .way(way), .evicted(evicted),
		.hit_total(hit_total), .miss_total(miss_total)
	);

	// cache model state
	logic [TAG_BITS-1:0] tags  [NUM_SETS][WAYS];
	logic                vld   [NUM_SETS][WAYS];
	logic [1:0]          rank  [NUM_SETS][WAYS];
	logic [31:0]         hits_seen, misses_seen;

	logic [31:0] addr_queue[$];      // requests waiting for the driver
	lookup_t     lookup_queue[$];    // expected results, oldest first
	int          errors = 0;
	int          quiet_cycles = 0;
	bit          sender_paused = 1'b0;
	bit          sender_noidle = 1'b0;
	bit          receiver_noidle = 1'b0;
	int          receiver_hold = 0;  // cycles the receiver still holds off

	initial begin
		forever #5 clk = ~clk;
	end

	// Predict one lookup and update the model.
	function automatic lookup_t predict_lookup(input logic [31:0] a);
		lookup_t r;
		int s;
		logic [TAG_BITS-1:0] t;
		int w;
		bit found;
		logic [2:0] lim;
		s = a[OFF_BITS +: IDX_BITS];
		t = a[31 -: TAG_BITS];
		found = 0;
		w = 0;
		r = '0;
		for (int k = 0; k < WAYS; k++)
			if (!found && vld[s][k] && tags[s][k] == t) begin
				found = 1;
				w = k;
			end
		if (found) begin
			lim = {1'b0, rank[s][w]};
		end else begin
			lim = 3'd5;
			w = -1;
			for (int k = 0; k < WAYS; k++)
				if (w < 0 && !vld[s][k])
					w = k;
			if (w < 0) begin
				// evict: oldest rank, lowest way on ties
				w = 0;
				for (int k = 1; k < WAYS; k++)
					if (rank[s][k] > rank[s][w])
						w = k;
				r.evicted = 1'b1;
			end
		end
		for (int k = 0; k < WAYS; k++)
			if (k != w && vld[s][k] && {1'b0, rank[s][k]} < lim)
				rank[s][k] = rank[s][k] + 2'd1;
		rank[s][w] = 2'd0;
		if (found) begin
			if (hits_seen != 32'hFFFF_FFFF)
				hits_seen++;
		end else begin
			tags[s][w] = t;
			vld[s][w] = 1'b1;
			if (misses_seen != 32'hFFFF_FFFF)
				misses_seen++;
		end
		r.hit = found;
		r.way = w[1:0];
		r.hit_total = hits_seen;
		r.miss_total = misses_seen;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// driver: next request is loaded in the same step the current one leaves
	always @(posedge clk) begin
		if (arst_n) begin
			if (!valid || ready) begin
				if (addr_queue.size() > 0 && !sender_paused &&
						(sender_noidle || $urandom_range(99) >= 29)) begin
					valid <= 1'b1;
					address <= addr_queue.pop_front();
				end else begin
					valid <= 1'b0;
				end
			end
		end
	end

	// model runs on acceptance
	always @(posedge clk)
		if (arst_n && valid && ready)
			lookup_queue.push_back(predict_lookup(address));

	// receiver ready, with an optional long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (receiver_hold > 0) begin
				receiver_hold <= receiver_hold - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= receiver_noidle || ($urandom_range(99) >= 29);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && out_valid && out_ready) begin
			if (lookup_queue.size() == 0) begin
				report_mismatch("unexpected result", 32'd0, 32'd0);
			end else begin
				want = lookup_queue.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", hit, want.hit);
				if (way !== want.way)
					report_mismatch("way", way, want.way);
				if (evicted !== want.evicted)
					report_mismatch("evicted", evicted, want.evicted);
				if (hit_total !== want.hit_total)
					report_mismatch("hit_total", hit_total, want.hit_total);
				if (miss_total !== want.miss_total)
					report_mismatch("miss_total", miss_total, want.miss_total);
			end
		end
	end

	// watchdog: cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((valid && ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("set_assoc_cache_lru_lookup_unit regression: fail");
			$finish;
		end
	end

	function automatic logic [31:0] make_addr(input int s, input logic [TAG_BITS-1:0] t);
		return {t, s[IDX_BITS-1:0], 5'($urandom_range(31))};
	endfunction

	initial begin
		int n;
		int hot_set;
		logic [TAG_BITS-1:0] pool [6];
		for (int s = 0; s < NUM_SETS; s++)
			for (int k = 0; k < WAYS; k++) begin
				vld[s][k] = 1'b0;
				rank[s][k] = 2'd0;
				tags[s][k] = '0;
			end
		hits_seen = 0;
		misses_seen = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, fill of all ways, hit reordering, evictions
		addr_queue.push_back(32'h0000_0000);
		addr_queue.push_back(32'hFFFF_FFFF);
		addr_queue.push_back(32'h0000_001F);       // hit same line
		addr_queue.push_back(32'hFFFF_FFE0);       // hit top line
		for (int k = 1; k <= 5; k++)               // fill set 0, then evict
			addr_queue.push_back({TAG_BITS'(k), 6'd0, 5'd0});
		addr_queue.push_back({TAG_BITS'(2), 6'd0, 5'd0});  // hit the LRU way
		addr_queue.push_back({TAG_BITS'(6), 6'd0, 5'd0});  // evict LRU
		addr_queue.push_back({TAG_BITS'(3), 6'd0, 5'd0});
		addr_queue.push_back({TAG_BITS'(7), 6'd0, 5'd0});
		addr_queue.push_back(32'hAAAA_AAAA);
		addr_queue.push_back(32'h5555_5555);
		addr_queue.push_back(32'hAAAA_AAAA);
		addr_queue.push_back(32'h5555_5555);
		wait (addr_queue.size() == 0 && lookup_queue.size() == 0);

		// receiver holds off while sender keeps offering
		sender_noidle = 1'b1;
		receiver_hold = 60;
		for (int i = 0; i < 40; i++)
			addr_queue.push_back($urandom());
		wait (addr_queue.size() == 0);
		sender_noidle = 1'b0;

		// sender pauses until all results are in
		sender_paused = 1'b1;
		wait (lookup_queue.size() == 0 && !valid);
		sender_paused = 1'b0;

		// random: mostly a few hot sets with a small tag pool per phase
		n = 0;
		while (n < 1360) begin
			if (n == 600) begin
				wait (addr_queue.size() == 0);
				sender_noidle = 1'b1;
				receiver_noidle = 1'b1;
			end
			if (n == 800) begin
				wait (addr_queue.size() == 0);
				sender_noidle = 1'b0;
				receiver_noidle = 1'b0;
			end
			if (n % 80 == 0) begin
				hot_set = $urandom_range(NUM_SETS - 1);
				foreach (pool[i])
					pool[i] = TAG_BITS'($urandom());
			end
			case ($urandom_range(9))
				0, 1: addr_queue.push_back($urandom());
				2: addr_queue.push_back(make_addr($urandom_range(NUM_SETS - 1),
					pool[$urandom_range(5)]));
				default: addr_queue.push_back(make_addr(hot_set, pool[$urandom_range(5)]));
			endcase
			n++;
			if (addr_queue.size() > 8)
				wait (addr_queue.size() <= 8);
		end
		wait (addr_queue.size() == 0 && !valid && lookup_queue.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("set_assoc_cache_lru_lookup_unit regression: pass");
		else
			$display("set_assoc_cache_lru_lookup_unit regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
